/* hw/rtl/hbq_pkg.sv */
// ----------------------------------------------------------------------------
// hbq_pkg - shared types and constants for the binned histogram quantile block
// Mode and register codes, sequencer states, binning constants and the
// structs passed between the config, binning and sequencer logic.
// ----------------------------------------------------------------------------
package hbq_pkg;

	// item modes
	localparam logic [1:0] MODE_ACC   = 2'd0;
	localparam logic [1:0] MODE_QUERY = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_ISO_SEL   = 2'd0;
	localparam logic [1:0] REG_PT_THR    = 2'd1;
	localparam logic [1:0] REG_Q_FRAC    = 2'd2;
	localparam logic [1:0] REG_MIN_TOTAL = 2'd3;

	// isolation select codes
	localparam logic [1:0] ISO_CHARGED = 2'd0;
	localparam logic [1:0] ISO_PHOTON  = 2'd1;
	localparam logic [1:0] ISO_NEUTRAL = 2'd2;
	localparam logic [1:0] ISO_NH_PH   = 2'd3;

	// register reset values
	localparam logic [1:0]  RST_ISO_SEL   = 2'd3;
	localparam logic [15:0] RST_PT_THR    = 16'd320;
	localparam logic [15:0] RST_Q_FRAC    = 16'd58982;
	localparam logic [23:0] RST_MIN_TOTAL = 24'd500;

	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	// |eta| edges in 1/1024 units
	localparam int EDGE_COUNT = 4;
	localparam logic [12:0] ETA_EDGE [EDGE_COUNT] = '{13'd819, 13'd1331, 13'd2048, 13'd2252};
	localparam int ETA_MAX_ABS = 2560;

	// isolation binning, 0.01 GeV units
	localparam int ISO_LOW        = -100;
	localparam int ISO_STEP       = 5;
	localparam int LOWSTAT_CUTOFF = 99900;
	// x/5 == (x*RECIP5) >> RECIP5_SHIFT for all x below 2^18
	localparam int RECIP5       = 52429;
	localparam int RECIP5_SHIFT = 18;

	// widths sized for the largest parameter values
	localparam int SLICE_W   = 9;
	localparam int ISO_BIN_W = 11;
	localparam int ISO_V_W   = 13;

	localparam int FRAC_W = 16;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BASE,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_SUM,
		ST_MUL,
		ST_SCAN,
		ST_DONE
	} hbq_state_t;

	typedef struct packed {
		logic [1:0]  iso_select;
		logic [15:0] pt_threshold;
		logic [15:0] quantile_fraction;
		logic [23:0] min_total;
	} hbq_cfg_t;

	typedef struct packed {
		logic                 keep;      // record passes all cuts
		logic                 slice_ok;  // query slice in range
		logic [SLICE_W-1:0]   slice;     // eta*RHO_BINS + rho
		logic [ISO_BIN_W-1:0] iso_bin;
	} hbq_bin_t;

endpackage

/* hw/rtl/hbq_ram.sv */
// ----------------------------------------------------------------------------
// hbq_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hbq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 55250
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/hbq_cfg.sv */
// ----------------------------------------------------------------------------
// hbq_cfg - APB-style configuration registers
// Four registers at byte addresses 0, 4, 8 and 12; zero wait states.
// ----------------------------------------------------------------------------
module hbq_cfg
	import hbq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output hbq_cfg_t              cfg
);

	hbq_cfg_t   cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.iso_select        <= RST_ISO_SEL;
			cfg_q.pt_threshold      <= RST_PT_THR;
			cfg_q.quantile_fraction <= RST_Q_FRAC;
			cfg_q.min_total         <= RST_MIN_TOTAL;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ISO_SEL:   cfg_q.iso_select        <= pwdata[1:0];
				REG_PT_THR:    cfg_q.pt_threshold      <= pwdata[15:0];
				REG_Q_FRAC:    cfg_q.quantile_fraction <= pwdata[15:0];
				REG_MIN_TOTAL: cfg_q.min_total         <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ISO_SEL:   prdata = CFG_DATA_W'(cfg_q.iso_select);
			REG_PT_THR:    prdata = CFG_DATA_W'(cfg_q.pt_threshold);
			REG_Q_FRAC:    prdata = CFG_DATA_W'(cfg_q.quantile_fraction);
			REG_MIN_TOTAL: prdata = CFG_DATA_W'(cfg_q.min_total);
			default:       prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/hbq_bin.sv */
// ----------------------------------------------------------------------------
// hbq_bin - record cuts and bin lookup
// Applies the pt, truth, |eta|, rho and isolation cuts, finds the eta, rho
// and isolation bins, or the query slice, and registers them on a transfer.
// ----------------------------------------------------------------------------
module hbq_bin
	import hbq_pkg::*;
#(
	parameter int ETA_BINS = 5,
	parameter int RHO_BINS = 50,
	parameter int ISO_BINS = 220
) (
	input  logic               clk,
	input  logic               load,
	input  hbq_cfg_t           cfg,
	input  logic [1:0]         mode,
	input  logic [15:0]        pt,
	input  logic signed [12:0] eta_sc,
	input  logic [15:0]        rho_value,
	input  logic signed [15:0] iso_charged,
	input  logic signed [15:0] iso_neutral_hadron,
	input  logic signed [15:0] iso_photon,
	input  logic               truth_match,
	input  logic [2:0]         query_eta_bin,
	input  logic [5:0]         query_rho_bin,
	output hbq_bin_t           bin
);

	localparam int ISO_SPAN = ISO_STEP * ISO_BINS;
	localparam int PROD_W   = ISO_V_W + 16;

	logic [12:0]          eta_u;
	logic [12:0]          aeta;
	logic                 eta_ok;
	logic [2:0]           ieta;
	logic [7:0]           rho_bin;
	logic                 rho_ok;
	logic signed [16:0]   iso_sel;
	logic signed [17:0]   iso_off;
	logic                 iso_ok;
	logic                 iso_ovf;
	logic [PROD_W-1:0]    iso_prod;
	logic [ISO_BIN_W-1:0] iso_bin;
	logic [SLICE_W-1:0]   acc_slice;
	logic [SLICE_W-1:0]   qry_slice;
	logic                 qry_ok;
	hbq_bin_t             bin_d;
	hbq_bin_t             bin_q;

	assign eta_u  = eta_sc;
	assign aeta   = eta_sc[12] ? (~eta_u + 13'd1) : eta_u;
	assign eta_ok = aeta <= 13'(ETA_MAX_ABS);

	// edges are increasing, so the bin is the number of edges passed
	always_comb begin
		ieta = 3'd0;
		for (int k = 0; k < EDGE_COUNT; k++) begin
			if ((k < ETA_BINS - 1) && (aeta > ETA_EDGE[k])) begin
				ieta = ieta + 3'd1;
			end
		end
	end

	assign rho_bin = rho_value[15:8];
	assign rho_ok  = rho_bin < 8'(RHO_BINS);

	always_comb begin
		case (cfg.iso_select)
			ISO_CHARGED: iso_sel = 17'(iso_charged);
			ISO_PHOTON:  iso_sel = 17'(iso_photon);
			ISO_NEUTRAL: iso_sel = 17'(iso_neutral_hadron);
			default:     iso_sel = 17'(iso_neutral_hadron) + 17'(iso_photon);
		endcase
	end

	assign iso_off = 18'(iso_sel) - 18'(ISO_LOW);
	assign iso_ok  = !iso_off[17];
	assign iso_ovf = iso_off[16:0] >= 17'(ISO_SPAN);

	// below the overflow bin the offset fits ISO_V_W bits
	assign iso_prod = PROD_W'(iso_off[ISO_V_W-1:0]) * PROD_W'(RECIP5);
	assign iso_bin  = iso_ovf ? ISO_BIN_W'(ISO_BINS)
	                          : iso_prod[RECIP5_SHIFT +: ISO_BIN_W];

	assign acc_slice = SLICE_W'(ieta) * SLICE_W'(RHO_BINS) + SLICE_W'(rho_bin);
	assign qry_slice = SLICE_W'(query_eta_bin) * SLICE_W'(RHO_BINS) + SLICE_W'(query_rho_bin);
	assign qry_ok    = ({1'b0, query_eta_bin} < 4'(ETA_BINS))
	                && ({1'b0, query_rho_bin} < 7'(RHO_BINS));

	always_comb begin
		bin_d.keep     = (pt > cfg.pt_threshold) && truth_match && eta_ok && rho_ok && iso_ok;
		bin_d.slice_ok = qry_ok;
		bin_d.slice    = (mode == MODE_QUERY) ? qry_slice : acc_slice;
		bin_d.iso_bin  = iso_bin;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bin_q <= bin_d;
		end
	end

	assign bin = bin_q;

endmodule

/* hw/rtl/binned_histogram_quantile_cutoff.sv */
// ----------------------------------------------------------------------------
// binned_histogram_quantile_cutoff - saturating 3D histogram with quantile
// Counts records by |eta|, rho and isolation bin; a query scans one slice and
// returns its total and the isolation cutoff at a programmable fraction.
//
//   transfer   valid      stall       payload
//   input      in_valid   in_stall    mode .. query_rho_bin
//   output     out_valid  out_stall   cutoff_value, slice_total, low_statistics
//   config     psel/penable/pwrite/pready, paddr, pwdata, prdata
//
// Accumulate: a bin, address, counter read and counter write step per record;
// a cut record stops after the address step. Query: two passes over the slice
// through the single counter RAM read port, with a 16-step shift-add for the
// fraction product between them. Clear and reset: one RAM entry per cycle over
// all ETA_BINS*RHO_BINS*(ISO_BINS+1) entries (55250 by default), with in_stall
// high. A result waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
module binned_histogram_quantile_cutoff
	import hbq_pkg::*;
#(
	parameter int ETA_BINS    = 5,
	parameter int RHO_BINS    = 50,
	parameter int ISO_BINS    = 220,
	parameter int COUNT_WIDTH = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	// input items
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            mode,
	input  logic [15:0]           pt,
	input  logic signed [12:0]    eta_sc,
	input  logic [15:0]           rho_value,
	input  logic signed [15:0]    iso_charged,
	input  logic signed [15:0]    iso_neutral_hadron,
	input  logic signed [15:0]    iso_photon,
	input  logic                  truth_match,
	input  logic [2:0]            query_eta_bin,
	input  logic [5:0]            query_rho_bin,
	// results
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [17:0]    cutoff_value,
	output logic [31:0]           slice_total,
	output logic                  low_statistics
);

	localparam int ISO_SLOTS  = ISO_BINS + 1;
	localparam int STORE_SIZE = ETA_BINS * RHO_BINS * ISO_SLOTS;
	localparam int ADDR_W     = $clog2(STORE_SIZE);
	localparam int CNT_W      = $clog2(ISO_SLOTS + 1);
	localparam int TOT_W      = COUNT_WIDTH + $clog2(ISO_SLOTS);
	localparam int LIM_W      = TOT_W + FRAC_W;
	localparam int BASE_W     = SLICE_W + ISO_BIN_W + 1;

	hbq_cfg_t   cfg;
	hbq_bin_t   bin;
	hbq_state_t state_q, state_d;

	logic                   in_accept;
	logic [1:0]             mode_q;
	logic [ADDR_W-1:0]      base_q;
	logic [BASE_W-1:0]      base_full;
	logic [ISO_BIN_W-1:0]   off;
	logic [ADDR_W-1:0]      rd_addr;
	logic [ADDR_W-1:0]      clr_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [3:0]             mcnt_q;
	logic                   scan;
	logic                   issue;
	logic                   rvld_q;
	logic                   rlast_q;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	logic [COUNT_WIDTH-1:0] rdata;
	logic [COUNT_WIDTH-1:0] inc;
	logic [TOT_W-1:0]       total_q;
	logic [TOT_W-1:0]       count_q;
	logic [TOT_W-1:0]       count_n;
	logic [LIM_W-1:0]       limit_q;
	logic signed [17:0]     edge_q;
	logic signed [17:0]     cutoff_q;
	logic [63:0]            total_ext;
	logic                   low;
	logic                   out_load;
	logic                   out_valid_q;
	logic signed [17:0]     cutoff_value_q;
	logic [31:0]            slice_total_q;
	logic                   low_statistics_q;

	hbq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hbq_bin #(
		.ETA_BINS (ETA_BINS),
		.RHO_BINS (RHO_BINS),
		.ISO_BINS (ISO_BINS)
	) u_bin (
		.clk                (clk),
		.load               (in_accept),
		.cfg                (cfg),
		.mode               (mode),
		.pt                 (pt),
		.eta_sc             (eta_sc),
		.rho_value          (rho_value),
		.iso_charged        (iso_charged),
		.iso_neutral_hadron (iso_neutral_hadron),
		.iso_photon         (iso_photon),
		.truth_match        (truth_match),
		.query_eta_bin      (query_eta_bin),
		.query_rho_bin      (query_rho_bin),
		.bin                (bin)
	);

	hbq_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (STORE_SIZE)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	assign in_accept = in_valid && !in_stall;

	// shared address adder: slice base plus bin or scan position
	assign base_full = BASE_W'(bin.slice) * BASE_W'(ISO_SLOTS);
	assign off       = scan ? ISO_BIN_W'(cnt_q) : bin.iso_bin;
	assign rd_addr   = base_q + ADDR_W'(off);
	assign inc       = (rdata == '1) ? rdata : rdata + COUNT_WIDTH'(1);
	assign issue     = scan && (cnt_q != CNT_W'(ISO_SLOTS));
	assign count_n   = count_q + TOT_W'(rdata);
	assign total_ext = 64'(total_q);
	assign low       = total_ext < 64'(cfg.min_total);

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = rd_addr;
		ram_wdata = inc;
		scan      = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == ADDR_W'(STORE_SIZE - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (mode) inside
						MODE_ACC, MODE_QUERY: state_d = ST_BASE;
						MODE_CLEAR:           state_d = ST_CLEAR;
						default:              state_d = ST_IDLE;
					endcase
				end
			end
			ST_BASE: begin
				if (mode_q == MODE_QUERY) begin
					state_d = bin.slice_ok ? ST_SUM : ST_DONE;
				end else begin
					state_d = bin.keep ? ST_ACC_RD : ST_IDLE;
				end
			end
			ST_ACC_RD: state_d = ST_ACC_WR;
			ST_ACC_WR: begin
				ram_we  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SUM: begin
				scan = 1'b1;
				if (rlast_q) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mcnt_q == 4'd15) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				scan = 1'b1;
				if (rlast_q) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			mcnt_q      <= '0;
			rvld_q      <= 1'b0;
			rlast_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR && clr_q != ADDR_W'(STORE_SIZE - 1)) begin
				clr_q <= clr_q + ADDR_W'(1);
			end else begin
				clr_q <= '0;
			end
			if (!scan) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			mcnt_q  <= (state_q == ST_MUL) ? mcnt_q + 4'd1 : 4'd0;
			rvld_q  <= issue;
			rlast_q <= issue && (cnt_q == CNT_W'(ISO_SLOTS - 1));
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_q   <= mode;
			total_q  <= '0;
			count_q  <= '0;
			limit_q  <= '0;
			cutoff_q <= '0;
			edge_q   <= 18'(ISO_LOW + ISO_STEP);
		end
		if (state_q == ST_BASE) begin
			base_q <= ADDR_W'(base_full);
		end
		if (state_q == ST_SUM && rvld_q) begin
			total_q <= total_q + TOT_W'(rdata);
		end
		// limit = fraction * total, MSB of the fraction first
		if (state_q == ST_MUL) begin
			limit_q <= {limit_q[LIM_W-2:0], 1'b0}
			         + (cfg.quantile_fraction[4'd15 - mcnt_q] ? LIM_W'(total_q) : '0);
		end
		// running count is monotonic, so once it reaches the limit it stays there
		if (state_q == ST_SCAN && rvld_q) begin
			count_q <= count_n;
			edge_q  <= edge_q + signed'(18'(ISO_STEP));
			if ({count_n, {FRAC_W{1'b0}}} < limit_q) begin
				cutoff_q <= edge_q;
			end
		end
		if (out_load) begin
			cutoff_value_q   <= low ? 18'(LOWSTAT_CUTOFF) : cutoff_q;
			slice_total_q    <= (total_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total_ext[31:0];
			low_statistics_q <= low;
		end
	end

	assign out_valid      = out_valid_q;
	assign cutoff_value   = cutoff_value_q;
	assign slice_total    = slice_total_q;
	assign low_statistics = low_statistics_q;

	a_ram_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_ACC_WR))
		else $error("counter RAM written outside clear or accumulate");

	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC_WR) |-> ($past(state_q) == ST_ACC_RD))
		else $error("counter write without preceding read");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (count_q <= total_q))
		else $error("scan count exceeds slice total");

	a_clear_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && $past(state_q) == ST_CLEAR)
		|-> ($past(clr_q) == ADDR_W'(STORE_SIZE - 1)))
		else $error("clear pass ended early");

endmodule
